@@ design/hts_pkg.sv @@
`default_nettype none

package hts_pkg;

  // field widths
  localparam int ALT_W = 24;
  localparam int COL_W = 10;
  localparam int CH_W  = 8;

  // default of the row buffer depth
  localparam int MAX_WIDTH_DEF = 1024;

  // output buffer
  localparam int OUT_DEPTH = 4;
  localparam int PTR_W     = $clog2(OUT_DEPTH);
  localparam int OCC_W     = $clog2(OUT_DEPTH + 1);

  // red, green, blue
  localparam int CHANNELS = 3;

  // register map, index = paddr[3:2]
  localparam logic [1:0] REG_SEA_LEVEL  = 2'd0;
  localparam logic [1:0] REG_OCEAN_EN   = 2'd1;
  localparam logic [1:0] REG_LINE_WIDTH = 2'd2;

  // reset values of the registers
  localparam logic signed [23:0] SEA_LEVEL_RST  = 24'sd0;
  localparam logic               OCEAN_EN_RST   = 1'b1;
  localparam logic [10:0]        LINE_WIDTH_RST = 11'd720;

  // slope factor: m = 3200 - 3*s clamped, factor = floor(256*m/25)
  localparam logic signed [28:0] SLOPE_BIAS = 29'sd3200;
  localparam logic [12:0]        SLOPE_MIN  = 13'd1760;
  localparam logic [12:0]        SLOPE_MAX  = 13'd4640;
  localparam logic [21:0]        RECIP_25   = 22'd2684355;  // ceil(2^26/25)

  // ramp spans and reciprocals, ceil(2^32/span)
  localparam logic [12:0] WATER_SPAN  = 13'd3520;
  localparam logic [12:0] LAND_SPAN   = 13'd4160;
  localparam logic [20:0] RECIP_WATER = 21'd1220162;
  localparam logic [20:0] RECIP_LAND  = 21'd1032445;

  // one pixel to be coloured
  typedef struct packed {
    logic                    valid;
    logic signed [ALT_W-1:0] alt;
    logic signed [ALT_W-1:0] right;
    logic signed [ALT_W-1:0] above;
    logic [COL_W-1:0]        col;
    logic                    last;
  } pix_req_t;

  // one finished pixel
  typedef struct packed {
    logic [CH_W-1:0]  red;
    logic [CH_W-1:0]  green;
    logic [CH_W-1:0]  blue;
    logic [COL_W-1:0] col;
    logic             last;
  } pix_out_t;

  // ramp base per channel
  function automatic logic [7:0] ramp_base(input logic water, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd0:    v = water ? 8'd30  : 8'd70;
      2'd1:    v = water ? 8'd70  : 8'd95;
      2'd2:    v = water ? 8'd120 : 8'd60;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

  // ramp gain per channel
  function automatic logic [7:0] ramp_coef(input logic water, input logic [1:0] ch);
    logic [7:0] v;
    case (ch)
      2'd0:    v = water ? 8'd40 : 8'd165;
      2'd1:    v = water ? 8'd70 : 8'd140;
      2'd2:    v = water ? 8'd90 : 8'd150;
      default: v = 8'd0;
    endcase
    return v;
  endfunction

endpackage

`default_nettype wire

@@ design/hts_row_mem.sv @@
`default_nettype none

module hts_row_mem #(
  parameter int DEPTH = hts_pkg::MAX_WIDTH_DEF
) (
  input  wire logic                                clk,
  input  wire logic                                wr_en,
  input  wire logic [$clog2(DEPTH)-1:0]            wr_addr,
  input  wire logic signed [hts_pkg::ALT_W-1:0]    wr_data,
  input  wire logic                                rd_en,
  input  wire logic [$clog2(DEPTH)-1:0]            rd_addr,
  output logic signed [hts_pkg::ALT_W-1:0]         rd_data
);

  logic signed [hts_pkg::ALT_W-1:0] mem_r [DEPTH];

  // write port
  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem_r[wr_addr] <= wr_data;
    end
  end

  // read port, registered data
  always_ff @(posedge clk) begin
    if (rd_en) begin
      rd_data <= mem_r[rd_addr];
    end
  end

endmodule

`default_nettype wire

@@ design/hts_shade_pipe.sv @@
`default_nettype none

module hts_shade_pipe (
  input  wire logic                             clk,
  input  wire logic                             rst_n,
  input  wire logic signed [hts_pkg::ALT_W-1:0] sea_level,
  input  wire logic                             ocean_en,
  input  wire hts_pkg::pix_req_t                req,
  output logic                                  pix_valid,
  output hts_pkg::pix_out_t                     pix
);

  // stage 1 comb
  logic signed [24:0] dr, du, dd, nd;
  logic signed [25:0] s_sum;
  logic signed [28:0] s_ext, s3, m_raw;
  logic [12:0]        m_nxt, u_nxt;
  logic               water_nxt;

  // stage registers
  logic                    s1_v_r, s2_v_r, s3_v_r, s4_v_r;
  logic                    s1_water_r, s2_water_r, s3_water_r, s4_water_r;
  logic [12:0]             s1_m_r, s1_u_r;
  logic [hts_pkg::COL_W-1:0] s1_col_r, s2_col_r, s3_col_r, s4_col_r;
  logic                    s1_last_r, s2_last_r, s3_last_r, s4_last_r;
  logic [15:0]             s2_fac_r, s3_fac_r;
  logic [19:0]             s2_vc_r [hts_pkg::CHANNELS];
  logic [7:0]              s3_q_r  [hts_pkg::CHANNELS];
  logic [7:0]              s4_c_r  [hts_pkg::CHANNELS];
  logic [23:0]             s4_p_r  [hts_pkg::CHANNELS];

  // stage 2..4 comb
  logic [42:0] fac_prod;
  logic [20:0] vc_full [hts_pkg::CHANNELS];
  logic [40:0] q_prod  [hts_pkg::CHANNELS];
  logic [20:0] recip;
  logic [8:0]  c_sum   [hts_pkg::CHANNELS];
  logic [8:0]  shaded  [hts_pkg::CHANNELS];
  logic [7:0]  chan    [hts_pkg::CHANNELS];

  // slope sum, slope factor numerator and ramp position
  always_comb begin
    dr    = $signed({req.right[23], req.right}) - $signed({req.alt[23], req.alt});
    du    = $signed({req.above[23], req.above}) - $signed({req.alt[23], req.alt});
    s_sum = $signed({dr[24], dr}) + $signed({du[24], du});
    s_ext = $signed({{3{s_sum[25]}}, s_sum});
    s3    = (s_ext <<< 1) + s_ext;
    m_raw = hts_pkg::SLOPE_BIAS - s3;
    if (m_raw < $signed({16'd0, hts_pkg::SLOPE_MIN})) begin
      m_nxt = hts_pkg::SLOPE_MIN;
    end else if (m_raw > $signed({16'd0, hts_pkg::SLOPE_MAX})) begin
      m_nxt = hts_pkg::SLOPE_MAX;
    end else begin
      m_nxt = m_raw[12:0];
    end

    dd        = $signed({sea_level[23], sea_level}) - $signed({req.alt[23], req.alt});
    nd        = -dd;
    water_nxt = ocean_en && (dd > 25'sd0);
    if (water_nxt) begin
      // depth below sea, saturated
      if (dd >= $signed({12'd0, hts_pkg::WATER_SPAN})) begin
        u_nxt = 13'd0;
      end else begin
        u_nxt = hts_pkg::WATER_SPAN - dd[12:0];
      end
    end else if (dd > 25'sd0) begin
      u_nxt = 13'd0;
    end else if (nd > $signed({12'd0, hts_pkg::LAND_SPAN})) begin
      u_nxt = hts_pkg::LAND_SPAN;
    end else begin
      u_nxt = nd[12:0];
    end
  end

  // factor = floor(256*m/25), ramp products per channel
  always_comb begin
    fac_prod = 43'({s1_m_r, 8'd0}) * 43'(hts_pkg::RECIP_25);
    for (int i = 0; i < hts_pkg::CHANNELS; i++) begin
      vc_full[i] = 21'(s1_u_r) * 21'(hts_pkg::ramp_coef(s1_water_r, 2'(i)));
    end
  end

  // divide by the ramp span through its reciprocal
  always_comb begin
    recip = s2_water_r ? hts_pkg::RECIP_WATER : hts_pkg::RECIP_LAND;
    for (int i = 0; i < hts_pkg::CHANNELS; i++) begin
      q_prod[i] = 41'(s2_vc_r[i]) * 41'(recip);
    end
  end

  // add base
  always_comb begin
    for (int i = 0; i < hts_pkg::CHANNELS; i++) begin
      c_sum[i] = 9'(hts_pkg::ramp_base(s3_water_r, 2'(i))) + 9'(s3_q_r[i]);
    end
  end

  // scale by slope and saturate, water goes unshaded
  always_comb begin
    for (int i = 0; i < hts_pkg::CHANNELS; i++) begin
      shaded[i] = s4_p_r[i][23:15];
      if (s4_water_r) begin
        chan[i] = s4_c_r[i];
      end else if (shaded[i][8]) begin
        chan[i] = 8'hFF;
      end else begin
        chan[i] = shaded[i][7:0];
      end
    end
  end

  assign pix_valid = s4_v_r;
  assign pix.red   = chan[0];
  assign pix.green = chan[1];
  assign pix.blue  = chan[2];
  assign pix.col   = s4_col_r;
  assign pix.last  = s4_last_r;

  // valid chain
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      s1_v_r <= 1'b0;
      s2_v_r <= 1'b0;
      s3_v_r <= 1'b0;
      s4_v_r <= 1'b0;
    end else begin
      s1_v_r <= req.valid;
      s2_v_r <= s1_v_r;
      s3_v_r <= s2_v_r;
      s4_v_r <= s3_v_r;
    end
  end

  // payload stages
  always_ff @(posedge clk) begin
    s1_water_r <= water_nxt;
    s1_m_r     <= m_nxt;
    s1_u_r     <= u_nxt;
    s1_col_r   <= req.col;
    s1_last_r  <= req.last;

    s2_water_r <= s1_water_r;
    s2_fac_r   <= fac_prod[41:26];
    s2_col_r   <= s1_col_r;
    s2_last_r  <= s1_last_r;

    s3_water_r <= s2_water_r;
    s3_fac_r   <= s2_fac_r;
    s3_col_r   <= s2_col_r;
    s3_last_r  <= s2_last_r;

    s4_water_r <= s3_water_r;
    s4_col_r   <= s3_col_r;
    s4_last_r  <= s3_last_r;

    for (int i = 0; i < hts_pkg::CHANNELS; i++) begin
      s2_vc_r[i] <= vc_full[i][19:0];
      s3_q_r[i]  <= q_prod[i][39:32];
      s4_c_r[i]  <= c_sum[i][7:0];
      s4_p_r[i]  <= 24'(c_sum[i][7:0]) * 24'(s3_fac_r);
    end
  end

endmodule

`default_nettype wire

@@ design/hts_out_fifo.sv @@
`default_nettype none

module hts_out_fifo (
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              push,
  input  wire hts_pkg::pix_out_t push_data,
  output logic                   pop_valid,
  input  wire logic              pop_ready,
  output hts_pkg::pix_out_t      pop_data
);

  hts_pkg::pix_out_t               buf_r [hts_pkg::OUT_DEPTH];
  logic [hts_pkg::PTR_W-1:0]       wr_ptr_r, rd_ptr_r;
  logic [hts_pkg::OCC_W-1:0]       count_r;
  logic                            pop;

  assign pop_valid = (count_r != '0);
  assign pop       = pop_valid && pop_ready;
  assign pop_data  = buf_r[rd_ptr_r];

  // pointers and fill count; the producer reserves space before it pushes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      count_r  <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= wr_ptr_r + 1'b1;
      end
      if (pop) begin
        rd_ptr_r <= rd_ptr_r + 1'b1;
      end
      count_r <= count_r + hts_pkg::OCC_W'(push) - hts_pkg::OCC_W'(pop);
    end
  end

  // storage
  always_ff @(posedge clk) begin
    if (push) begin
      buf_r[wr_ptr_r] <= push_data;
    end
  end

endmodule

`default_nettype wire

@@ design/height_tint_slope_shader_core.sv @@
`default_nettype none

// Hypsometric tint with hillshade over a raster stream of signed Q20.4 altitudes.
// Each pixel is coloured from its own altitude, its right neighbour (the last
// column wraps to column 0) and the pixel above, which is kept in a row memory
// of MAX_WIDTH entries; on the first row of a map the pixel is its own upper
// neighbour. A pixel leaves when the next pixel of its row arrives, so the
// first beat of a row gives no result and the last beat gives two (tlast marks
// the final result of each input beat). ST_IDLE accepts a beat and makes the
// synchronous row-memory read; ST_READ writes back and issues the held pixel,
// and on the last pixel of a row ST_EMIT2 issues the wrapped last pixel.
// Results pass the shade pipeline and a 4-entry output buffer; the input stalls
// while fewer than two buffer places are free. line_width values below 2 act as
// 2 and above MAX_WIDTH as MAX_WIDTH. Registers are to be written only while the
// block is idle; the block does not enforce it. The row memory needs no clearing.
module height_tint_slope_shader_core #(
  parameter int MAX_WIDTH = hts_pkg::MAX_WIDTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  // input beat
  input  wire logic        in_tvalid,
  output logic             in_tready,
  input  wire logic [23:0] in_tdata,   // [23:0] altitude
  input  wire logic        in_tuser,   // [0] frame_start
  // result beat
  output logic             out_tvalid,
  input  wire logic        out_tready,
  output logic [39:0]      out_tdata,  // [7:0] red, [15:8] green, [23:16] blue, [33:24] column
  output logic             out_tlast,  // last_of_run
  // register port
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [3:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  localparam int AW = $clog2(MAX_WIDTH);
  localparam int WW = $clog2(MAX_WIDTH + 1);

  localparam logic [1:0] ST_IDLE  = 2'd0;
  localparam logic [1:0] ST_READ  = 2'd1;
  localparam logic [1:0] ST_EMIT2 = 2'd2;

  // registers
  logic signed [23:0] sea_level_r;
  logic               ocean_en_r;
  logic [10:0]        line_width_r;
  logic               cfg_wr;

  // sequencer and row state
  logic [1:0]         state_r, state_nxt;
  logic [AW-1:0]      col_cnt_r;
  logic               first_row_r;
  logic signed [23:0] a_r, held_alt_r, held_above_r, row_first_r;
  logic [AW-1:0]      x_r;
  logic               last_r, cur_first_r;

  // accept path
  logic               in_accept;
  logic [AW-1:0]      x_acc;
  logic [WW-1:0]      x_plus, w_eff;
  logic               first_acc, last_acc;

  // memory
  logic               mem_wr_en, mem_rd_en;
  logic [AW-1:0]      mem_wr_addr, mem_rd_addr;
  logic signed [23:0] mem_rd_data, above;

  // shade and output
  hts_pkg::pix_req_t  req;
  logic               pix_valid, out_pop;
  hts_pkg::pix_out_t  pix, out_pix;
  logic [hts_pkg::OCC_W-1:0] occ_r;

  // register port
  assign cfg_pready = 1'b1;
  assign cfg_wr     = cfg_psel && cfg_penable && cfg_pwrite && cfg_pready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      sea_level_r  <= hts_pkg::SEA_LEVEL_RST;
      ocean_en_r   <= hts_pkg::OCEAN_EN_RST;
      line_width_r <= hts_pkg::LINE_WIDTH_RST;
    end else if (cfg_wr) begin
      case (cfg_paddr[3:2])
        hts_pkg::REG_SEA_LEVEL:  sea_level_r  <= cfg_pwdata[23:0];
        hts_pkg::REG_OCEAN_EN:   ocean_en_r   <= cfg_pwdata[0];
        hts_pkg::REG_LINE_WIDTH: line_width_r <= cfg_pwdata[10:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (cfg_paddr[3:2])
      hts_pkg::REG_SEA_LEVEL:  cfg_prdata = {{8{sea_level_r[23]}}, sea_level_r};
      hts_pkg::REG_OCEAN_EN:   cfg_prdata = {31'd0, ocean_en_r};
      hts_pkg::REG_LINE_WIDTH: cfg_prdata = {21'd0, line_width_r};
      default:                 cfg_prdata = 32'd0;
    endcase
  end

  // input handshake: idle and room for two results
  assign in_tready = (state_r == ST_IDLE) &&
                     (occ_r <= hts_pkg::OCC_W'(hts_pkg::OUT_DEPTH - 2));
  assign in_accept = in_tvalid && in_tready;

  // column of the incoming pixel and end-of-row decision
  always_comb begin
    x_acc     = in_tuser ? '0 : col_cnt_r;
    first_acc = in_tuser || first_row_r;
    x_plus    = WW'(x_acc) + WW'(1);
    if (line_width_r < 11'd2) begin
      w_eff = WW'(2);
    end else if (32'(line_width_r) > 32'(MAX_WIDTH)) begin
      w_eff = WW'(MAX_WIDTH);
    end else begin
      w_eff = WW'(line_width_r);
    end
    last_acc = (x_plus >= w_eff);
  end

  // read at accept, write back in the next cycle; reads are made only in ST_IDLE
  // and writes only in ST_READ, so a read never meets a write to the same entry
  assign mem_rd_en   = in_accept;
  assign mem_rd_addr = x_acc;
  assign mem_wr_en   = (state_r == ST_READ);
  assign mem_wr_addr = x_r;
  assign above       = cur_first_r ? a_r : mem_rd_data;

  hts_row_mem #(
    .DEPTH(MAX_WIDTH)
  ) u_row_mem (
    .clk     (clk),
    .wr_en   (mem_wr_en),
    .wr_addr (mem_wr_addr),
    .wr_data (a_r),
    .rd_en   (mem_rd_en),
    .rd_addr (mem_rd_addr),
    .rd_data (mem_rd_data)
  );

  // pixel issue: held pixel in the read cycle, wrapped last pixel after it
  always_comb begin
    req       = '0;
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: begin
        if (in_accept) begin
          state_nxt = ST_READ;
        end
      end
      ST_READ: begin
        req.valid = (x_r != '0);
        req.alt   = held_alt_r;
        req.right = a_r;
        req.above = held_above_r;
        req.col   = hts_pkg::COL_W'(x_r - AW'(1));
        req.last  = !last_r;
        state_nxt = last_r ? ST_EMIT2 : ST_IDLE;
      end
      ST_EMIT2: begin
        req.valid = 1'b1;
        req.alt   = held_alt_r;
        req.right = row_first_r;
        req.above = held_above_r;
        req.col   = hts_pkg::COL_W'(x_r);
        req.last  = 1'b1;
        state_nxt = ST_IDLE;
      end
      default: begin
        state_nxt = ST_IDLE;
      end
    endcase
  end

  // control state
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= ST_IDLE;
      col_cnt_r   <= '0;
      first_row_r <= 1'b1;
    end else begin
      state_r <= state_nxt;
      if (in_accept) begin
        col_cnt_r   <= last_acc ? '0 : AW'(x_plus);
        first_row_r <= last_acc ? 1'b0 : first_acc;
      end
    end
  end

  // per-item payload
  always_ff @(posedge clk) begin
    if (in_accept) begin
      a_r         <= in_tdata;
      x_r         <= x_acc;
      last_r      <= last_acc;
      cur_first_r <= first_acc;
    end
    if (state_r == ST_READ) begin
      held_alt_r   <= a_r;
      held_above_r <= above;
      if (x_r == '0) begin
        row_first_r <= a_r;
      end
    end
  end

  hts_shade_pipe u_shade (
    .clk       (clk),
    .rst_n     (rst_n),
    .sea_level (sea_level_r),
    .ocean_en  (ocean_en_r),
    .req       (req),
    .pix_valid (pix_valid),
    .pix       (pix)
  );

  // results issued and not yet taken
  assign out_pop = out_tvalid && out_tready;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      occ_r <= '0;
    end else begin
      occ_r <= occ_r + hts_pkg::OCC_W'(req.valid) - hts_pkg::OCC_W'(out_pop);
    end
  end

  hts_out_fifo u_out_fifo (
    .clk       (clk),
    .rst_n     (rst_n),
    .push      (pix_valid),
    .push_data (pix),
    .pop_valid (out_tvalid),
    .pop_ready (out_tready),
    .pop_data  (out_pix)
  );

  assign out_tdata = {6'd0, out_pix.col, out_pix.blue, out_pix.green, out_pix.red};
  assign out_tlast = out_pix.last;

`ifndef SYNTHESIS
  a_occ_bound: assert property (@(posedge clk) disable iff (!rst_n)
    occ_r <= hts_pkg::OCC_W'(hts_pkg::OUT_DEPTH))
    else $error("result count exceeds output buffer");

  a_accept_read: assert property (@(posedge clk) disable iff (!rst_n)
    in_accept |=> state_r == ST_READ)
    else $error("accepted beat not followed by row read");

  a_no_rw_clash: assert property (@(posedge clk) disable iff (!rst_n)
    (mem_wr_en && mem_rd_en) |-> (mem_wr_addr != mem_rd_addr))
    else $error("row memory read and write hit the same entry");

  a_issue_state: assert property (@(posedge clk) disable iff (!rst_n)
    req.valid |-> (state_r == ST_READ || state_r == ST_EMIT2))
    else $error("pixel issued outside an issue state");

  a_out_occ: assert property (@(posedge clk) disable iff (!rst_n)
    out_tvalid |-> occ_r != '0)
    else $error("output valid with no result outstanding");
`endif

endmodule

`default_nettype wire

@@ bench/height_tint_slope_shader_core_tb.sv @@
module height_tint_slope_shader_core_tb;
  timeunit 1ns;
  timeprecision 1ps;

  localparam int CYCLE_LIMIT  = 400000;
  localparam int DRAIN_CYCLES = 16;
  localparam int ROW_DEPTH    = 1024;

  // receiver stall patterns
  typedef enum int {RX_OPEN, RX_SPARSE, RX_PERIODIC, RX_COIN, RX_SLOW} rx_mode_t;

  // one shaded pixel as it should leave the block
  typedef struct packed {
    logic [7:0] red;
    logic [7:0] green;
    logic [7:0] blue;
    logic [9:0] col;
    logic       last;
  } shade_px_t;

  logic        clk;
  logic        rst_n       = 1'b0;
  logic        in_tvalid   = 1'b0;
  logic        in_tready;
  logic [23:0] in_tdata    = '0;     // [23:0] altitude
  logic        in_tuser    = 1'b0;   // [0] frame_start
  logic        out_tvalid;
  logic        out_tready  = 1'b0;
  logic [39:0] out_tdata;            // [7:0] red, [15:8] green, [23:16] blue, [33:24] column
  logic        out_tlast;            // last_of_run
  logic        cfg_psel    = 1'b0;
  logic        cfg_penable = 1'b0;
  logic        cfg_pwrite  = 1'b0;
  logic [3:0]  cfg_paddr   = '0;
  logic [31:0] cfg_pwdata  = '0;
  logic [31:0] cfg_prdata;
  logic        cfg_pready;

  // shader state as the block should hold it
  logic signed [23:0] sea_q   = hts_pkg::SEA_LEVEL_RST;
  bit                 ocean_q = hts_pkg::OCEAN_EN_RST;
  logic [10:0]        width_q = hts_pkg::LINE_WIDTH_RST;
  logic signed [23:0] row_mem [0:ROW_DEPTH-1];
  bit                 row_written [0:ROW_DEPTH-1];
  logic signed [23:0] row_first  = '0;
  logic signed [23:0] held_alt   = '0;
  logic signed [23:0] held_above = '0;
  int                 col_cnt    = 0;
  bit                 first_row  = 1'b1;

  shade_px_t expected_px[$];

  // bookkeeping
  int       errors       = 0;
  int       items_sent   = 0;
  int       frames       = 0;
  int       results_seen = 0;
  int       cfg_writes   = 0;
  int       random_items = 0;
  int       burst_left   = 0;
  bit       tx_steady    = 1'b0;
  rx_mode_t rx_mode      = RX_OPEN;
  int       rx_tick      = 0;
  int       cycle_count  = 0;
  logic signed [23:0] last_alt = '0;

  height_tint_slope_shader_core DUT (
    .clk        (clk),
    .rst_n      (rst_n),
    .in_tvalid  (in_tvalid),
    .in_tready  (in_tready),
    .in_tdata   (in_tdata),
    .in_tuser   (in_tuser),
    .out_tvalid (out_tvalid),
    .out_tready (out_tready),
    .out_tdata  (out_tdata),
    .out_tlast  (out_tlast),
    .cfg_psel   (cfg_psel),
    .cfg_penable(cfg_penable),
    .cfg_pwrite (cfg_pwrite),
    .cfg_paddr  (cfg_paddr),
    .cfg_pwdata (cfg_pwdata),
    .cfg_prdata (cfg_prdata),
    .cfg_pready (cfg_pready)
  );

  // 20 ns clock
  always begin
    clk = 1'b0;
    #10;
    clk = 1'b1;
    #10;
  end

  // slope scaling of one land channel, saturated to 8 bits
  function automatic longint tint_scale(input longint c, input longint fac);
    longint v;
    v = (c * fac) >>> 15;
    return (v > 255) ? 255 : v;
  endfunction

  // colour of one pixel from itself, its right and its upper neighbour
  function automatic shade_px_t colour_px(input logic signed [23:0] alt,
                                          input logic signed [23:0] right,
                                          input logic signed [23:0] above,
                                          input int col, input bit last);
    longint a, rt, ab, sea, s, n, fac, d, r, g, b;
    shade_px_t px;
    a   = alt;
    rt  = right;
    ab  = above;
    sea = sea_q;
    s = (rt - a) + (ab - a);
    n = 3276800 - 3072 * s;
    if (n < 1802240) n = 1802240;
    if (n > 4751360) n = 4751360;
    fac = n / 100;
    if (a < sea && ocean_q) begin
      // depth tint, no shading
      d = sea - a;
      if (d > 3520) d = 3520;
      d = 3520 - d;
      r = 30 + d * 40 / 3520;
      g = 70 + d * 70 / 3520;
      b = 120 + d * 90 / 3520;
    end else begin
      d = a - sea;
      if (d < 0) d = 0;
      if (d > 4160) d = 4160;
      r = tint_scale(70 + d * 165 / 4160, fac);
      g = tint_scale(95 + d * 140 / 4160, fac);
      b = tint_scale(60 + d * 150 / 4160, fac);
    end
    px.red   = r[7:0];
    px.green = g[7:0];
    px.blue  = b[7:0];
    px.col   = col[9:0];
    px.last  = last;
    return px;
  endfunction

  // advance the raster state by one accepted altitude beat
  function automatic void predict_pixel(input logic signed [23:0] alt, input bit fs);
    int w, x;
    bit last;
    logic signed [23:0] above;
    w = width_q;
    if (w < 2) w = 2;
    if (w > ROW_DEPTH) w = ROW_DEPTH;
    if (fs) begin
      col_cnt   = 0;
      first_row = 1'b1;
    end
    x = (col_cnt > ROW_DEPTH - 1) ? ROW_DEPTH - 1 : col_cnt;
    last = (x + 1 >= w);
    above = first_row ? alt : row_mem[x];
    row_mem[x]     = alt;
    row_written[x] = 1'b1;
    if (x == 0) begin
      row_first = alt;
    end else begin
      expected_px.push_back(colour_px(held_alt, alt, held_above, x - 1, !last));
    end
    if (last) begin
      // wrapped right neighbour is the first pixel of the row
      expected_px.push_back(colour_px(alt, row_first, above, x, 1'b1));
      col_cnt   = 0;
      first_row = 1'b0;
    end else begin
      held_alt   = alt;
      held_above = above;
      col_cnt    = x + 1;
    end
  endfunction

  // altitude mix: near sea level, small slopes, extremes and full range
  function automatic logic [23:0] gen_altitude();
    int v, base, r;
    case ($urandom_range(0, 9))
      0, 1: begin
        v = $urandom;
      end
      2: begin
        case ($urandom_range(0, 3))
          0:       v = -8388608;
          1:       v = 8388607;
          2:       v = sea_q;
          default: v = sea_q - 1;
        endcase
      end
      3, 4, 5, 6: begin
        base = sea_q;
        r = $urandom_range(0, 9000);
        v = base + r - 4500;
      end
      default: begin
        base = last_alt;
        r = $urandom_range(0, 800);
        v = base + r - 400;
      end
    endcase
    last_alt = v[23:0];
    return v[23:0];
  endfunction

  // register write, setup then access, ends on an idle bus
  task automatic apb_write(input logic [1:0] idx, input logic [31:0] val);
    cfg_psel    <= 1'b1;
    cfg_pwrite  <= 1'b1;
    cfg_penable <= 1'b0;
    cfg_paddr   <= {idx, 2'b00};
    cfg_pwdata  <= val;
    @(negedge clk);
    cfg_penable <= 1'b1;
    @(posedge clk);
    while (!cfg_pready) @(posedge clk);
    case (idx)
      hts_pkg::REG_SEA_LEVEL:  sea_q   = val[23:0];
      hts_pkg::REG_OCEAN_EN:   ocean_q = val[0];
      hts_pkg::REG_LINE_WIDTH: width_q = val[10:0];
      default: ;
    endcase
    cfg_writes++;
    @(negedge clk);
    cfg_psel    <= 1'b0;
    cfg_penable <= 1'b0;
    cfg_pwrite  <= 1'b0;
    @(negedge clk);
  endtask

  // one altitude beat, with burst gaps unless the sender runs steady
  task automatic push_pixel(input logic signed [23:0] alt, input bit fs);
    int gap;
    // a row read must never hit a row-memory entry that was never written
    if (!fs && !first_row && !row_written[col_cnt]) fs = 1'b1;
    if (!tx_steady) begin
      if (burst_left == 0) begin
        gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 6);
        if (gap > 0) begin
          in_tvalid <= 1'b0;
          repeat (gap) @(negedge clk);
        end
        burst_left = $urandom_range(1, 24);
      end
      burst_left--;
    end
    in_tvalid <= 1'b1;
    in_tdata  <= alt;
    in_tuser  <= fs;
    @(posedge clk);
    while (!in_tready) @(posedge clk);
    predict_pixel(alt, fs);
    items_sent++;
    if (fs) frames++;
    @(negedge clk);
  endtask

  // stop sending, let all pending pixels out, then let the block settle
  task automatic drain_results();
    in_tvalid <= 1'b0;
    while (expected_px.size() != 0) @(negedge clk);
    repeat (DRAIN_CYCLES) @(negedge clk);
  endtask

  // reset register values, first row of a wide map
  task automatic test_reset_config();
    rx_mode = RX_OPEN;
    push_pixel(24'sd0, 1'b1);
    push_pixel(-24'sd16, 1'b0);
    push_pixel(24'sd8388607, 1'b0);
    drain_results();
  endtask

  // width below range acts as two, altitude extremes drive slope clamps
  task automatic test_narrow_rows();
    apb_write(hts_pkg::REG_LINE_WIDTH, 32'd0);
    rx_mode = RX_PERIODIC;
    push_pixel(-24'sd8388608, 1'b1);
    push_pixel(24'sd8388607, 1'b0);
    push_pixel(24'sd8388607, 1'b0);
    push_pixel(-24'sd8388608, 1'b0);
    push_pixel(24'sd0, 1'b0);
    push_pixel(24'sd4160, 1'b0);
    drain_results();
  endtask

  // sea level at both ends, ocean on then off
  task automatic test_sea_extremes();
    apb_write(hts_pkg::REG_SEA_LEVEL, 32'h007F_FFFF);
    apb_write(hts_pkg::REG_LINE_WIDTH, 32'd3);
    rx_mode = RX_COIN;
    push_pixel(24'sd8388607, 1'b1);
    push_pixel(24'sd8388606, 1'b0);
    push_pixel(-24'sd8388608, 1'b0);
    drain_results();
    apb_write(hts_pkg::REG_SEA_LEVEL, 32'h0080_0000);
    apb_write(hts_pkg::REG_OCEAN_EN, 32'd0);
    push_pixel(-24'sd8388608, 1'b0);
    push_pixel(24'sd0, 1'b0);
    push_pixel(-24'sd100, 1'b0);
    drain_results();
    apb_write(hts_pkg::REG_SEA_LEVEL, 32'd0);
    apb_write(hts_pkg::REG_OCEAN_EN, 32'd1);
  endtask

  // frame start in the middle of a row drops the held pixel
  task automatic test_frame_restart();
    apb_write(hts_pkg::REG_LINE_WIDTH, 32'd4);
    rx_mode = RX_SLOW;
    push_pixel(24'sd100, 1'b1);
    push_pixel(-24'sd200, 1'b0);
    push_pixel(24'sd50, 1'b1);
    push_pixel(24'sd3000, 1'b0);
    push_pixel(24'sd2500, 1'b0);
    push_pixel(24'sd4000, 1'b0);
    drain_results();
  endtask

  // width cut below the current column ends the row on the next beat
  task automatic test_width_shrink();
    rx_mode = RX_SPARSE;
    push_pixel(24'sd400, 1'b0);
    push_pixel(-24'sd300, 1'b0);
    push_pixel(24'sd1200, 1'b0);
    drain_results();
    apb_write(hts_pkg::REG_LINE_WIDTH, 32'd2);
    push_pixel(24'sd800, 1'b0);
    drain_results();
  endtask

  // one full row at the widest map, then a width above range acts as widest
  task automatic test_full_width();
    apb_write(hts_pkg::REG_LINE_WIDTH, 32'd1024);
    apb_write(hts_pkg::REG_SEA_LEVEL, 32'd0);
    rx_mode = RX_COIN;
    for (int i = 0; i < ROW_DEPTH; i++) begin
      push_pixel(gen_altitude(), i == 0);
    end
    drain_results();
    apb_write(hts_pkg::REG_LINE_WIDTH, 32'd2047);
    rx_mode = RX_OPEN;
    for (int i = 0; i < 4; i++) begin
      push_pixel(gen_altitude(), 1'b0);
    end
    drain_results();
  endtask

  // random maps under random register settings and pacing
  task automatic test_random_maps();
    int w, sea, n_items;
    bit fs;
    while (random_items < 60) begin
      case ($urandom_range(0, 7))
        0:       w = $urandom_range(0, 1);
        1, 2:    w = $urandom_range(40, 90);
        default: w = $urandom_range(2, 16);
      endcase
      case ($urandom_range(0, 5))
        0:       sea = 0;
        1:       sea = $urandom;
        default: sea = $urandom_range(0, 40000) - 20000;
      endcase
      apb_write(hts_pkg::REG_LINE_WIDTH, w);
      apb_write(hts_pkg::REG_SEA_LEVEL, sea & 32'h00FF_FFFF);
      apb_write(hts_pkg::REG_OCEAN_EN, $urandom_range(0, 1));
      tx_steady = ($urandom_range(0, 3) == 0);
      rx_mode   = rx_mode_t'($urandom_range(0, 4));
      n_items   = $urandom_range(8, 24);
      for (int i = 0; i < n_items; i++) begin
        fs = (i == 0 && $urandom_range(0, 1) == 1) || $urandom_range(0, 39) == 0;
        push_pixel(gen_altitude(), fs);
        random_items++;
      end
      drain_results();
    end
  endtask

  // receiver ready pattern
  always @(negedge clk) begin
    rx_tick <= rx_tick + 1;
    case (rx_mode)
      RX_OPEN:     out_tready <= 1'b1;
      RX_SPARSE:   out_tready <= ($urandom_range(0, 3) != 0);
      RX_PERIODIC: out_tready <= ((rx_tick % 7) < 4);
      RX_COIN:     out_tready <= $urandom_range(0, 1);
      default:     out_tready <= ((rx_tick % 16) >= 12);
    endcase
  end

  // compare each result beat with the oldest expected pixel
  always @(posedge clk) begin : check_results
    shade_px_t got, want;
    if (rst_n && out_tvalid && out_tready) begin
      got.red   = out_tdata[7:0];
      got.green = out_tdata[15:8];
      got.blue  = out_tdata[23:16];
      got.col   = out_tdata[33:24];
      got.last  = out_tlast;
      results_seen++;
      if (expected_px.size() == 0) begin
        errors++;
        $display("%0t: unexpected pixel r=%0d g=%0d b=%0d col=%0d last=%0b", $time,
                 got.red, got.green, got.blue, got.col, got.last);
      end else begin
        want = expected_px.pop_front();
        if (got !== want || out_tdata[39:34] !== 6'd0) begin
          errors++;
          $display("%0t: pixel mismatch, expected r=%0d g=%0d b=%0d col=%0d last=%0b",
                   $time, want.red, want.green, want.blue, want.col, want.last);
          $display("%0t:                 actual r=%0d g=%0d b=%0d col=%0d last=%0b pad=%h",
                   $time, got.red, got.green, got.blue, got.col, got.last,
                   out_tdata[39:34]);
        end
      end
    end
  end

  // run time guard
  always @(posedge clk) begin
    cycle_count <= cycle_count + 1;
    if (cycle_count == CYCLE_LIMIT) begin
      $display("timeout after %0d cycles, %0d pixels still pending", cycle_count,
               expected_px.size());
      $display("FAIL height_tint_slope_shader_core");
      $finish;
    end
  end

  initial begin
    repeat (5) @(negedge clk);
    rst_n <= 1'b1;
    @(negedge clk);
    test_reset_config();
    test_narrow_rows();
    test_sea_extremes();
    test_frame_restart();
    test_width_shrink();
    test_full_width();
    test_random_maps();
    drain_results();
    $display("%0d altitude beats over %0d frame starts, %0d register writes", items_sent,
             frames, cfg_writes);
    $display("%0d shaded pixels checked, %0d mismatches", results_seen, errors);
    if (errors == 0 && expected_px.size() == 0) begin
      $display("PASS height_tint_slope_shader_core");
    end else begin
      $display("FAIL height_tint_slope_shader_core");
    end
    $finish;
  end

endmodule

@@ height_tint_slope_shader_core.f @@
design/hts_pkg.sv
design/hts_row_mem.sv
design/hts_shade_pipe.sv
design/hts_out_fifo.sv
design/height_tint_slope_shader_core.sv
bench/height_tint_slope_shader_core_tb.sv
